[sv/efm_pkg.sv]
`default_nettype none
package efm_pkg;

    // chunk width of the partial-product multipliers
    localparam int CHUNK_W  = 32;
    localparam int ENERGY_W = 24;
    localparam int MASS_W   = 23;
    localparam int QUOT_W   = 24;
    // divider: sign stage, range stage, one stage per quotient bit
    localparam int DIV_LAT  = QUOT_W + 2;

    localparam logic [MASS_W-1:0] MASS_RESET = 23'd125000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOROOT = 2'd1,
        ST_NEG    = 2'd2,
        ST_OVF    = 2'd3
    } status_t;

    // control word handed to the divider
    typedef struct packed {
        logic    go;
        status_t pre;
    } div_ctl_t;

    function automatic int max2(int x, int y);
        return (x > y) ? x : y;
    endfunction

    // latency of efm_mul: operand register, one stage per chunk pair, sign stage
    function automatic int mul_lat(int wa, int wb);
        return ((wa + CHUNK_W - 1) >> 5) * ((wb + CHUNK_W - 1) >> 5) + 2;
    endfunction

endpackage
`default_nettype wire

[sv/energy_from_mass_constraint.sv]
// channel  | direction | ports                       | content
// ---------+-----------+-----------------------------+-------------------------------------
// s_       | in        | s_tvalid s_tready s_tdata    | two four-momenta per word
// m_       | out       | m_tvalid m_tready m_tdata    | constrained energy, status in tuser
// cfg_     | in        | cfg_valid cfg_ready cfg_data | target_mass register
//
// One word accepted per cycle unless m_tready stalls the pipe; the pipe runs through the
// multiplier chain (partial-product stages), the square root (one bit per stage) and the
// 26-stage divider.
// aresetn (synchronous) clears the valid pipe and loads target_mass with 125000.
// A stall on m_tready freezes the whole pipe; s_tready follows it.
`default_nettype none
module energy_from_mass_constraint #(
    parameter int MOMENTUM_BITS = 24
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    // fixed_px, fixed_py, fixed_pz, fixed_energy, adjusted_px, adjusted_py,
    // adjusted_pz, adjusted_energy (lowest first), zero padded to bytes
    input  wire logic [((6*MOMENTUM_BITS+48+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // new_energy
    output logic [efm_pkg::ENERGY_W-1:0]                      m_tdata,
    // status
    output logic [1:0]                                        m_tuser,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    input  wire logic [efm_pkg::MASS_W-1:0]                   cfg_data,
    input  wire logic                                         cfg_valid,
    output logic                                              cfg_ready
);
    import efm_pkg::*;

    localparam int P    = MOMENTUM_BITS;
    localparam int EW   = ENERGY_W + 1;
    localparam int MW   = MASS_W + 1;
    localparam int WPP  = 2 * P;
    localparam int WEE  = 2 * EW;
    localparam int WMM  = 2 * MW;
    localparam int WSQ  = 2 * P + 1;
    localparam int WM   = max2(WEE, WSQ) + 1;
    localparam int WC   = WM + 2;
    localparam int WCC  = 2 * WC;
    localparam int WEM  = WEE + WM;
    localparam int WDD  = 2 * WSQ;
    localparam int WEP  = WEE + WSQ;
    localparam int WEC  = EW + WC;
    localparam int WT   = max2(WCC, WEM + 2) + 1;
    localparam int WA   = max2(WEP, WDD) + 1;
    localparam int WPT  = WSQ + WT;
    localparam int WMD  = WM + WDD;
    localparam int WECP = WEC + WSQ;
    localparam int WK   = max2(WPT, WMD + 2) + 1;
    localparam int WX   = 2 * (WK / 2);
    localparam int H    = WX / 2;
    localparam int WS1  = H + 1;
    localparam int WDS  = WSQ + WS1;
    localparam int WN   = max2(WECP, WDS) + 1;
    localparam int WD   = WA + 1;

    localparam int O_E1 = 3 * P;
    localparam int O_P2 = 3 * P + ENERGY_W;
    localparam int O_E2 = 6 * P + ENERGY_W;

    localparam int LAT1 = max2(mul_lat(P, P), max2(mul_lat(EW, EW), mul_lat(MW, MW)));
    localparam int T2   = LAT1 + 4;
    localparam int LAT2 = max2(max2(mul_lat(WC, WC), mul_lat(WEE, WM)),
                               max2(max2(mul_lat(WSQ, WSQ), mul_lat(WEE, WSQ)),
                                    mul_lat(EW, WC)));
    localparam int T4   = T2 + LAT2 + 1;
    localparam int LAT3 = max2(mul_lat(WSQ, WT), max2(mul_lat(WM, WDD), mul_lat(WEC, WSQ)));
    localparam int T5   = T4 + LAT3;
    localparam int T6   = T5 + 1;
    localparam int T7   = T6 + H;
    localparam int LAT4 = mul_lat(WSQ, WS1);
    localparam int T8   = T7 + LAT4;
    localparam int TOT  = T8 + DIV_LAT;

    logic en;
    logic [MASS_W-1:0] target_mass_reg;
    logic [TOT-1:0]    vld_reg;

    // handshake: the whole pipe advances unless the output word is stuck
    assign en        = m_tready || !m_tvalid;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[TOT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_mass_reg <= MASS_RESET;
        end else if (cfg_valid) begin
            target_mass_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOT-2:0], s_tvalid};
        end
    end

    // unpack input word
    logic signed [P-1:0]  p1x, p1y, p1z, p2x, p2y, p2z;
    logic signed [EW-1:0] e1s, e2s;
    logic signed [MW-1:0] mts;

    assign p1x = $signed(s_tdata[P-1:0]);
    assign p1y = $signed(s_tdata[2*P-1:P]);
    assign p1z = $signed(s_tdata[3*P-1:2*P]);
    assign p2x = $signed(s_tdata[O_P2+P-1:O_P2]);
    assign p2y = $signed(s_tdata[O_P2+2*P-1:O_P2+P]);
    assign p2z = $signed(s_tdata[O_P2+3*P-1:O_P2+2*P]);
    assign e1s = $signed({1'b0, s_tdata[O_E1+ENERGY_W-1:O_E1]});
    assign e2s = $signed({1'b0, s_tdata[O_E2+ENERGY_W-1:O_E2]});
    assign mts = $signed({1'b0, target_mass_reg});

    // level 1: squares and dot-product terms
    logic signed [WPP-1:0] xx1, yy1, zz1, xx2, yy2, zz2, dxp, dyp, dzp;
    logic signed [WEE-1:0] ee1, ee2;
    logic signed [WMM-1:0] mmp;

    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_xx1 (.aclk, .en, .a(p1x), .b(p1x), .p(xx1));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_yy1 (.aclk, .en, .a(p1y), .b(p1y), .p(yy1));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_zz1 (.aclk, .en, .a(p1z), .b(p1z), .p(zz1));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_xx2 (.aclk, .en, .a(p2x), .b(p2x), .p(xx2));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_yy2 (.aclk, .en, .a(p2y), .b(p2y), .p(yy2));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_zz2 (.aclk, .en, .a(p2z), .b(p2z), .p(zz2));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_dx  (.aclk, .en, .a(p1x), .b(p2x), .p(dxp));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_dy  (.aclk, .en, .a(p1y), .b(p2y), .p(dyp));
    efm_mul #(.WA(P), .WB(P), .LAT(LAT1)) u_dz  (.aclk, .en, .a(p1z), .b(p2z), .p(dzp));
    efm_mul #(.WA(EW), .WB(EW), .LAT(LAT1)) u_ee1 (.aclk, .en, .a(e1s), .b(e1s), .p(ee1));
    efm_mul #(.WA(EW), .WB(EW), .LAT(LAT1)) u_ee2 (.aclk, .en, .a(e2s), .b(e2s), .p(ee2));
    efm_mul #(.WA(MW), .WB(MW), .LAT(LAT1)) u_mm  (.aclk, .en, .a(mts), .b(mts), .p(mmp));

    // e1 travels beside the front stages
    logic [ENERGY_W-1:0] e1_t2;

    efm_dly #(.W(ENERGY_W), .N(T2)) u_e1_dly (
        .aclk, .en, .d(s_tdata[O_E1+ENERGY_W-1:O_E1]), .q(e1_t2)
    );

    // front adder stages: sums, mass differences, magnitudes, C2
    logic signed [WSQ-1:0] p1sq_s1, p2sq_s1, d_s1;
    logic signed [WEE-1:0] e1sq_s1, e2sq_s1;
    logic signed [WMM-1:0] mm_s1;

    logic signed [WM-1:0]  m1d_s2, m2d_s2;
    logic signed [WSQ-1:0] p2sq_s2, d_s2;
    logic signed [WEE-1:0] e1sq_s2;
    logic signed [WMM-1:0] mm_s2;
    logic                  bad_s2, perp_s2;

    logic signed [WM-1:0]  m1_s3, m2_s3;
    logic signed [WSQ-1:0] p2sq_s3, d_s3;
    logic signed [WEE-1:0] e1sq_s3;
    logic signed [WMM-1:0] mm_s3;
    logic                  bad_s3, perp_s3;

    logic signed [WC-1:0]  c2_s4;
    logic signed [WM-1:0]  m2_s4;
    logic signed [WSQ-1:0] p2sq_s4, d_s4;
    logic signed [WEE-1:0] e1sq_s4;
    logic                  bad_s4, perp_s4;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1sq_s1 <= WSQ'(xx1) + WSQ'(yy1) + WSQ'(zz1);
            p2sq_s1 <= WSQ'(xx2) + WSQ'(yy2) + WSQ'(zz2);
            d_s1    <= WSQ'(dxp) + WSQ'(dyp) + WSQ'(dzp);
            e1sq_s1 <= ee1;
            e2sq_s1 <= ee2;
            mm_s1   <= mmp;

            m1d_s2  <= WM'(e1sq_s1) - WM'(p1sq_s1);
            m2d_s2  <= WM'(e2sq_s1) - WM'(p2sq_s1);
            p2sq_s2 <= p2sq_s1;
            d_s2    <= d_s1;
            e1sq_s2 <= e1sq_s1;
            mm_s2   <= mm_s1;
            bad_s2  <= (p1sq_s1 == '0) || (p2sq_s1 == '0);
            perp_s2 <= (d_s1 == '0);

            m1_s3   <= m1d_s2[WM-1] ? -m1d_s2 : m1d_s2;
            m2_s3   <= m2d_s2[WM-1] ? -m2d_s2 : m2d_s2;
            p2sq_s3 <= p2sq_s2;
            d_s3    <= d_s2;
            e1sq_s3 <= e1sq_s2;
            mm_s3   <= mm_s2;
            bad_s3  <= bad_s2;
            perp_s3 <= perp_s2;

            c2_s4   <= WC'(mm_s3) - WC'(m1_s3) - WC'(m2_s3);
            m2_s4   <= m2_s3;
            p2sq_s4 <= p2sq_s3;
            d_s4    <= d_s3;
            e1sq_s4 <= e1sq_s3;
            bad_s4  <= bad_s3;
            perp_s4 <= perp_s3;
        end
    end

    // level 2
    logic signed [WCC-1:0] cc_p;
    logic signed [WEM-1:0] em_p;
    logic signed [WDD-1:0] dd_p;
    logic signed [WEP-1:0] ep_p;
    logic signed [WEC-1:0] ec_p;
    logic signed [EW-1:0]  e1_t2s;

    assign e1_t2s = $signed({1'b0, e1_t2});

    efm_mul #(.WA(WC), .WB(WC), .LAT(LAT2)) u_cc (
        .aclk, .en, .a(c2_s4), .b(c2_s4), .p(cc_p));
    efm_mul #(.WA(WEE), .WB(WM), .LAT(LAT2)) u_em (
        .aclk, .en, .a(e1sq_s4), .b(m2_s4), .p(em_p));
    efm_mul #(.WA(WSQ), .WB(WSQ), .LAT(LAT2)) u_dd (
        .aclk, .en, .a(d_s4), .b(d_s4), .p(dd_p));
    efm_mul #(.WA(WEE), .WB(WSQ), .LAT(LAT2)) u_ep (
        .aclk, .en, .a(e1sq_s4), .b(p2sq_s4), .p(ep_p));
    efm_mul #(.WA(EW), .WB(WC), .LAT(LAT2)) u_ec (
        .aclk, .en, .a(e1_t2s), .b(c2_s4), .p(ec_p));

    logic [WM+WSQ-1:0]     mp_t4;
    logic signed [WM-1:0]  m2_t4;
    logic signed [WSQ-1:0] p2sq_t4;

    efm_dly #(.W(WM+WSQ), .N(LAT2+1)) u_mp_dly (
        .aclk, .en, .d({m2_s4, p2sq_s4}), .q(mp_t4));

    assign m2_t4   = $signed(mp_t4[WM+WSQ-1:WSQ]);
    assign p2sq_t4 = $signed(mp_t4[WSQ-1:0]);

    // discriminant factor and quadratic term
    logic signed [WT-1:0]  t1_reg;
    logic signed [WA-1:0]  a_reg;
    logic signed [WDD-1:0] dd_s5;
    logic signed [WEC-1:0] ec_s5;

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= WT'(cc_p) - (WT'(em_p) <<< 2);
            a_reg  <= WA'(ep_p) - WA'(dd_p);
            dd_s5  <= dd_p;
            ec_s5  <= ec_p;
        end
    end

    // level 3
    logic signed [WPT-1:0]  pt_p;
    logic signed [WMD-1:0]  md_p;
    logic signed [WECP-1:0] ecp_p;

    efm_mul #(.WA(WSQ), .WB(WT), .LAT(LAT3)) u_pt (
        .aclk, .en, .a(p2sq_t4), .b(t1_reg), .p(pt_p));
    efm_mul #(.WA(WM), .WB(WDD), .LAT(LAT3)) u_md (
        .aclk, .en, .a(m2_t4), .b(dd_s5), .p(md_p));
    efm_mul #(.WA(WEC), .WB(WSQ), .LAT(LAT3)) u_ecp (
        .aclk, .en, .a(ec_s5), .b(p2sq_t4), .p(ecp_p));

    // K4
    logic signed [WK-1:0] k4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            k4_reg <= WK'(pt_p) + (WK'(md_p) <<< 2);
        end
    end

    logic [H-1:0] s_root;

    efm_sqrt #(.WX(WX)) u_sqrt (
        .aclk, .en, .x(WX'(k4_reg[WK-2:0])), .s(s_root));

    // d waits for the root
    logic [WSQ-1:0]        d_t7;
    logic signed [WDS-1:0] ds_p;

    efm_dly #(.W(WSQ), .N(T7-T2)) u_d_dly (.aclk, .en, .d(d_s4), .q(d_t7));

    efm_mul #(.WA(WSQ), .WB(WS1), .LAT(LAT4)) u_ds (
        .aclk, .en, .a($signed(d_t7)), .b($signed({1'b0, s_root})), .p(ds_p));

    // side paths aligned to the divider input
    logic [WECP-1:0] ecp_t8;
    logic [WA-1:0]   a_t8;
    logic            k4neg_t8;
    logic [2+WC+ENERGY_W-1:0] side_t8;
    logic                  bad_t8, perp_t8;
    logic signed [WC-1:0]  c2_t8;
    logic [ENERGY_W-1:0]   e1_t8;

    efm_dly #(.W(WECP), .N(T8-T5)) u_ecp_dly (.aclk, .en, .d(ecp_p), .q(ecp_t8));
    efm_dly #(.W(WA), .N(T8-T4)) u_a_dly (.aclk, .en, .d(a_reg), .q(a_t8));
    efm_dly #(.W(1), .N(T8-T6)) u_k4_dly (.aclk, .en, .d(k4_reg[WK-1]), .q(k4neg_t8));
    efm_dly #(.W(2+WC+ENERGY_W), .N(T8-T2)) u_side_dly (
        .aclk, .en, .d({bad_s4, perp_s4, c2_s4, e1_t2}), .q(side_t8));

    assign bad_t8  = side_t8[2+WC+ENERGY_W-1];
    assign perp_t8 = side_t8[WC+ENERGY_W];
    assign c2_t8   = $signed(side_t8[WC+ENERGY_W-1:ENERGY_W]);
    assign e1_t8   = side_t8[ENERGY_W-1:0];

    // pick the branch and the early status
    logic signed [WN-1:0] num_sel;
    logic signed [WD-1:0] den_sel;
    div_ctl_t             ctl_sel;
    logic                 azero;

    assign azero = (a_t8 == '0);

    always_comb begin
        if (perp_t8) begin
            num_sel = WN'(c2_t8);
            den_sel = $signed(WD'({e1_t8, 1'b0}));
        end else begin
            num_sel = WN'($signed(ecp_t8)) + WN'(ds_p);
            den_sel = WD'($signed(a_t8)) <<< 1;
        end
    end

    always_comb begin
        ctl_sel.go  = 1'b0;
        ctl_sel.pre = ST_OK;
        if (bad_t8) begin
            ctl_sel.pre = ST_NEG;
        end else if (perp_t8) begin
            if (e1_t8 == '0) begin
                ctl_sel.pre = ST_NOROOT;
            end else begin
                ctl_sel.go = 1'b1;
            end
        end else if (k4neg_t8 || azero) begin
            ctl_sel.pre = ST_NOROOT;
        end else begin
            ctl_sel.go = 1'b1;
        end
    end

    status_t st_out;

    efm_div #(.WN(WN), .WD(WD)) u_div (
        .aclk, .en, .num(num_sel), .den(den_sel), .ctl(ctl_sel),
        .quot(m_tdata), .st(st_out));

    assign m_tuser = st_out;

    // an error word carries no energy
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error word with nonzero energy");

    // nothing valid right after reset
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid word after reset");

    // a held output word stops the intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // a stalled pipe keeps its valid pattern
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid pipe moved during stall");

endmodule
`default_nettype wire

[sv/efm_mul.sv]
`default_nettype none
module efm_mul #(
    parameter int WA  = 24,
    parameter int WB  = 24,
    parameter int LAT = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [WA-1:0]  a,
    input  wire logic signed [WB-1:0]  b,
    output logic signed [WA+WB-1:0]    p
);
    import efm_pkg::*;

    localparam int NA  = (WA + CHUNK_W - 1) / CHUNK_W;
    localparam int NB  = (WB + CHUNK_W - 1) / CHUNK_W;
    localparam int MA  = NA * CHUNK_W;
    localparam int MBW = NB * CHUNK_W;
    localparam int NP  = MA + MBW;
    localparam int NS  = NA * NB;
    localparam int WP  = WA + WB;
    localparam int PAD = LAT - NS - 2;

    logic [WA-1:0]  a_mag;
    logic [WB-1:0]  b_mag;
    logic [MA-1:0]  am_reg  [0:NS-1];
    logic [MBW-1:0] bm_reg  [0:NS-1];
    logic [NP-1:0]  acc_reg [0:NS];
    logic           sg_reg  [0:NS];
    logic [NP-1:0]  res_full;
    logic [WP-1:0]  out_reg [0:PAD];

    // magnitudes; sign is carried beside them
    assign a_mag = a[WA-1] ? $unsigned(-a) : $unsigned(a);
    assign b_mag = b[WB-1] ? $unsigned(-b) : $unsigned(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg[0]  <= MA'(a_mag);
            bm_reg[0]  <= MBW'(b_mag);
            acc_reg[0] <= '0;
            sg_reg[0]  <= a[WA-1] ^ b[WB-1];
        end
    end

    // one 32x32 partial product accumulated per stage
    for (genvar k = 0; k < NS; k++) begin : g_pp
        localparam int IA = k % NA;
        localparam int IB = k / NA;
        logic [2*CHUNK_W-1:0] pp;
        logic [NP-1:0]        pp_sh;

        assign pp    = am_reg[k][IA*CHUNK_W +: CHUNK_W] * bm_reg[k][IB*CHUNK_W +: CHUNK_W];
        assign pp_sh = NP'(pp) << ((IA + IB) * CHUNK_W);

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[k+1] <= acc_reg[k] + pp_sh;
                sg_reg[k+1]  <= sg_reg[k];
            end
        end

        if (k < NS - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    am_reg[k+1] <= am_reg[k];
                    bm_reg[k+1] <= bm_reg[k];
                end
            end
        end
    end

    // restore sign
    assign res_full = sg_reg[NS] ? (~acc_reg[NS] + NP'(1)) : acc_reg[NS];

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg[0] <= res_full[WP-1:0];
        end
    end

    // padding so that a whole level shares one latency
    for (genvar k = 0; k < PAD; k++) begin : g_pad
        always_ff @(posedge aclk) begin
            if (en) begin
                out_reg[k+1] <= out_reg[k];
            end
        end
    end

    assign p = $signed(out_reg[PAD]);

endmodule
`default_nettype wire

[sv/efm_dly.sv]
`default_nettype none
module efm_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic [W-1:0]      q
);
    logic [W-1:0] sr_reg [0:N-1];

    // shift line, holds on stall
    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int k = 1; k < N; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule
`default_nettype wire

[sv/efm_sqrt.sv]
`default_nettype none
module efm_sqrt #(
    parameter int WX = 156
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [WX-1:0]   x,
    output logic [WX/2-1:0]      s
);
    localparam int H  = WX / 2;
    localparam int WR = WX + 1;

    logic [WR-1:0] rem_reg [1:H-1];
    logic [WR-1:0] res_reg [1:H];

    // one root bit per stage
    for (genvar k = 0; k < H; k++) begin : g_st
        logic [WR-1:0] r_in;
        logic [WR-1:0] q_in;
        logic [WR-1:0] bitv;
        logic [WR-1:0] t;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in = WR'(x);
            assign q_in = '0;
        end else begin : g_mid
            assign r_in = rem_reg[k];
            assign q_in = res_reg[k];
        end

        assign bitv = WR'(1) << (WX - 2 - 2 * k);
        assign t    = q_in + bitv;
        assign ge   = (r_in >= t);

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[k+1] <= ge ? ((q_in >> 1) + bitv) : (q_in >> 1);
            end
        end

        if (k < H - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? (r_in - t) : r_in;
                end
            end
        end
    end

    assign s = res_reg[H][H-1:0];

endmodule
`default_nettype wire

[sv/efm_div.sv]
`default_nettype none
module efm_div #(
    parameter int WN = 128,
    parameter int WD = 101
) (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic signed [WN-1:0]       num,
    input  wire logic signed [WD-1:0]       den,
    input  wire efm_pkg::div_ctl_t          ctl,
    output logic [efm_pkg::QUOT_W-1:0]      quot,
    output efm_pkg::status_t                st
);
    import efm_pkg::*;

    localparam int WL = max2(WN, WD + QUOT_W);

    logic [WN-1:0]     nm_reg;
    logic [WD-1:0]     dm_reg;
    logic              neg_reg;
    div_ctl_t          ctl_reg;
    logic [WL-1:0]     limit;
    status_t           st_b;
    logic [WL-1:0]     rem_reg [0:QUOT_W-1];
    logic [WD-1:0]     dv_reg  [0:QUOT_W-1];
    logic [QUOT_W-1:0] q_reg   [0:QUOT_W];
    status_t           st_reg  [0:QUOT_W];

    // sign check and magnitudes
    always_ff @(posedge aclk) begin
        if (en) begin
            nm_reg  <= num[WN-1] ? $unsigned(-num) : $unsigned(num);
            dm_reg  <= den[WD-1] ? $unsigned(-den) : $unsigned(den);
            neg_reg <= (num != '0) && (num[WN-1] != den[WD-1]);
            ctl_reg <= ctl;
        end
    end

    // range check: quotient must stay below 2^24
    assign limit = WL'(dm_reg) << QUOT_W;

    always_comb begin
        if (!ctl_reg.go) begin
            st_b = ctl_reg.pre;
        end else if (neg_reg) begin
            st_b = ST_NEG;
        end else if (WL'(nm_reg) >= limit) begin
            st_b = ST_OVF;
        end else begin
            st_b = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= WL'(nm_reg);
            dv_reg[0]  <= dm_reg;
            q_reg[0]   <= '0;
            st_reg[0]  <= st_b;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QUOT_W; k++) begin : g_bit
        localparam int IB = QUOT_W - 1 - k;
        logic [WL-1:0] t;
        logic          ge;

        assign t  = WL'(dv_reg[k]) << IB;
        assign ge = (rem_reg[k] >= t);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]  <= q_reg[k] | (QUOT_W'(ge) << IB);
                st_reg[k+1] <= st_reg[k];
            end
        end

        if (k < QUOT_W - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? (rem_reg[k] - t) : rem_reg[k];
                    dv_reg[k+1]  <= dv_reg[k];
                end
            end
        end
    end

    assign st   = st_reg[QUOT_W];
    assign quot = (st_reg[QUOT_W] == ST_OK) ? q_reg[QUOT_W] : '0;

endmodule
`default_nettype wire
